// File: hdl/deq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
// No dependencies; used by the interfaces and all queue modules.
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 4;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [VAL_W-1:0] word_t;
  typedef logic [FILL_W-1:0]       fill_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_PUSH_BACK  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic accept;
    logic load;
  } dp_ctrl_t;

  localparam cnt_t       DEPTH_CNT  = CNT_W'(DEPTH);
  localparam logic [IDX_W:0] DEPTH_WIDE = (IDX_W + 1)'(DEPTH);
  localparam idx_t       LAST_IDX   = IDX_W'(DEPTH - 1);

  function automatic idx_t wrap_add(idx_t a, idx_t b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_WIDE) begin
      sum = sum - DEPTH_WIDE;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic idx_t wrap_dec(idx_t a);
    idx_t res;
    if (a == '0) begin
      res = LAST_IDX;
    end else begin
      res = a - idx_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/deq_ifs.sv
// Command and result channel interfaces of the double-ended queue.
// Depends on deq_pkg.
`default_nettype none

interface deq_in_if;
  logic          valid;
  logic          ready;
  deq_pkg::cmd_e cmd;
  deq_pkg::word_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_out_if;
  logic             valid;
  logic             ready;
  deq_pkg::word_t   out_value;
  deq_pkg::status_e status;
  deq_pkg::fill_t   fill_count;

  modport source (output valid, output out_value, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input out_value, input status, input fill_count,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/deq_datapath.sv
// Queue datapath: slot memory, head pointer, fill count and result register.
// Depends on deq_pkg; driven by deq_ctrl through a dp_ctrl_t command.
`default_nettype none

module deq_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  deq_pkg::dp_ctrl_t      ctrl_i,
  input  deq_pkg::cmd_e          cmd_i,
  input  deq_pkg::word_t         value_i,
  output deq_pkg::word_t         out_value_o,
  output deq_pkg::status_e       status_o,
  output deq_pkg::fill_t         fill_count_o
);

  deq_pkg::word_t   mem [deq_pkg::DEPTH];
  deq_pkg::word_t   rdata_q;
  deq_pkg::idx_t    head_q, head_d;
  deq_pkg::cnt_t    count_q, count_d;
  deq_pkg::status_e pend_status_q, pend_status_d;
  logic             pend_pop_q, pend_pop_d;
  deq_pkg::word_t   out_value_q;
  deq_pkg::status_e out_status_q;
  deq_pkg::fill_t   out_fill_q;

  logic          full, empty, wr_en;
  deq_pkg::idx_t wr_addr, rd_addr;
  deq_pkg::idx_t head_dec, head_inc, back_idx, last_idx;
  deq_pkg::cnt_t count_dec;

  assign full      = (count_q == deq_pkg::DEPTH_CNT);
  assign empty     = (count_q == '0);
  assign count_dec = count_q - deq_pkg::cnt_t'(1);
  assign head_dec  = deq_pkg::wrap_dec(head_q);
  assign head_inc  = deq_pkg::wrap_add(head_q, deq_pkg::idx_t'(1));
  assign back_idx  = deq_pkg::wrap_add(head_q, count_q[deq_pkg::IDX_W-1:0]);
  assign last_idx  = deq_pkg::wrap_add(head_q, count_dec[deq_pkg::IDX_W-1:0]);

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    wr_en         = 1'b0;
    wr_addr       = head_q;
    rd_addr       = head_q;
    pend_status_d = deq_pkg::ST_DONE;
    pend_pop_d    = 1'b0;
    case (cmd_i)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          pend_status_d = deq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head_dec;
          head_d  = head_dec;
          count_d = count_q + deq_pkg::cnt_t'(1);
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          pend_status_d = deq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = back_idx;
          count_d = count_q + deq_pkg::cnt_t'(1);
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          pend_status_d = deq_pkg::ST_EMPTY;
        end else begin
          pend_pop_d = 1'b1;
          rd_addr    = head_q;
          head_d     = head_inc;
          count_d    = count_dec;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          pend_status_d = deq_pkg::ST_EMPTY;
        end else begin
          pend_pop_d = 1'b1;
          rd_addr    = last_idx;
          count_d    = count_dec;
        end
      end
      default: begin
        pend_status_d = deq_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      count_q       <= '0;
      pend_pop_q    <= 1'b0;
      pend_status_q <= deq_pkg::ST_DONE;
    end else if (ctrl_i.accept) begin
      head_q        <= head_d;
      count_q       <= count_d;
      pend_pop_q    <= pend_pop_d;
      pend_status_q <= pend_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      if (wr_en) begin
        mem[wr_addr] <= value_i;
      end
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      out_value_q  <= pend_pop_q ? rdata_q : '0;
      out_status_q <= pend_status_q;
      out_fill_q   <= deq_pkg::fill_t'(count_q);
    end
  end

  assign out_value_o  = out_value_q;
  assign status_o     = out_status_q;
  assign fill_count_o = out_fill_q;

endmodule

`default_nettype wire

// File: hdl/deq_ctrl.sv
// Queue controller: accept/execute state machine and result valid flag.
// Depends on deq_pkg; commands deq_datapath through a dp_ctrl_t.
`default_nettype none

module deq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output deq_pkg::dp_ctrl_t  ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;
  assign load       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ctrl_o.accept = accept;
  assign ctrl_o.load   = load;

endmodule

`default_nettype wire

// File: hdl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, deq_pkg::DEPTH deep.
// Each command transfer pushes or pops at the front or back and yields
// exactly one result transfer carrying the popped word (zero otherwise),
// a status (done, full, empty) and the fill count after the command.
// Each item passes two steps: one updates the pointers and reads the slot
// memory into its read register, one loads the result register when the
// output is free. The next command is taken once the result is loaded,
// even while it waits on the output. The slot memory needs no clearing.
// Depends on deq_pkg, deq_ifs, deq_ctrl and deq_datapath.
`default_nettype none

module double_ended_queue (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  deq_in_if.sink     in_i,
  deq_out_if.source  out_o
);

  deq_pkg::dp_ctrl_t ctrl;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  deq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cmd_i        (in_i.cmd),
    .value_i      (in_i.value),
    .out_value_o  (out_o.out_value),
    .status_o     (out_o.status),
    .fill_count_o (out_o.fill_count)
  );

endmodule

`default_nettype wire

// File: verif/tb_double_ended_queue.sv
// Testbench for double_ended_queue: directed command table, then random command
// streams biased toward the full and empty bounds, with random idling on both channels.
// Depends on deq_pkg, deq_ifs and the double_ended_queue RTL.
`default_nettype none

module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int unsigned RANDOM_CMDS = 1550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_IDLE    = 14;

  typedef struct packed {
    word_t   value;
    status_e status;
    fill_t   fill;
  } deq_result_t;

  typedef struct packed {
    cmd_e        cmd;
    word_t       value;
    logic        typed;
    deq_result_t outcome;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;

  deq_in_if  in_if ();
  deq_out_if out_if ();

  double_ended_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  word_t       slot_mem [DEPTH];
  int unsigned front_pos;
  int unsigned words_held;

  deq_result_t pending_results [$];
  cmd_row_t    cmd_table [$];
  int unsigned fault_count;
  int unsigned cycle_count;
  bit          send_burst;
  bit          take_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned draw_idle(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic apply_deque_cmd(input cmd_e c, input word_t v, output deq_result_t r);
    r = '{value: '0, status: ST_DONE, fill: '0};
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (words_held >= DEPTH) begin
          r.status = ST_FULL;
        end else if (c == CMD_PUSH_FRONT) begin
          front_pos = (front_pos + DEPTH - 1) % DEPTH;
          slot_mem[front_pos] = v;
          words_held++;
        end else begin
          slot_mem[(front_pos + words_held) % DEPTH] = v;
          words_held++;
        end
      end
      default: begin
        if (words_held == 0) begin
          r.status = ST_EMPTY;
        end else if (c == CMD_POP_FRONT) begin
          r.value = slot_mem[front_pos];
          front_pos = (front_pos + 1) % DEPTH;
          words_held--;
        end else begin
          r.value = slot_mem[(front_pos + words_held - 1) % DEPTH];
          words_held--;
        end
      end
    endcase
    r.fill = fill_t'(words_held);
  endtask

  task automatic send_cmd(input cmd_row_t row);
    int unsigned gap;
    deq_result_t r;
    gap = draw_idle(send_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= row.cmd;
    in_if.value <= row.value;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    apply_deque_cmd(row.cmd, row.value, r);
    pending_results.push_back(row.typed ? row.outcome : r);
  endtask

  task automatic add_row(input cmd_e c, input word_t v, input logic typed,
                         input word_t ev, input status_e es, input fill_t ef);
    cmd_table.push_back('{cmd: c, value: v, typed: typed,
                          outcome: '{value: ev, status: es, fill: ef}});
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned push_pct;
    cmd_row_t    row;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_PUSH_FRONT;
    in_if.value = '0;
    front_pos   = 0;
    words_held  = 0;
    fault_count = 0;
    cycle_count = 0;
    send_burst  = 1'b0;
    push_pct    = 50;

    add_row(CMD_POP_FRONT,  32'sh12345678, 1'b1, '0, ST_EMPTY, 4'd0);
    add_row(CMD_POP_BACK,   '1,            1'b1, '0, ST_EMPTY, 4'd0);
    add_row(CMD_PUSH_BACK,  32'sh7fffffff, 1'b1, '0, ST_DONE,  4'd1);
    add_row(CMD_PUSH_FRONT, 32'sh80000000, 1'b1, '0, ST_DONE,  4'd2);
    add_row(CMD_PUSH_BACK,  '0,            1'b1, '0, ST_DONE,  4'd3);
    add_row(CMD_PUSH_FRONT, '1,            1'b1, '0, ST_DONE,  4'd4);
    add_row(CMD_PUSH_FRONT, 32'sha5a5a5a5, 1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_PUSH_BACK,  32'sh5a5a5a5a, 1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_PUSH_FRONT, 32'sh00000001, 1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_PUSH_BACK,  32'shfffffffe, 1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_PUSH_BACK,  32'sh0badf00d, 1'b1, '0, ST_FULL,  4'd8);
    add_row(CMD_PUSH_FRONT, 32'shdeadbeef, 1'b1, '0, ST_FULL,  4'd8);
    add_row(CMD_POP_FRONT,  '1,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_BACK,   '0,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_FRONT,  '0,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_BACK,   '1,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_FRONT,  '0,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_BACK,   '0,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_FRONT,  '1,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_BACK,   '0,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_BACK,   '1,            1'b1, '0, ST_EMPTY, 4'd0);
    add_row(CMD_PUSH_FRONT, 32'sh12345678, 1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_BACK,   '0,            1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_PUSH_BACK,  32'sh13579bdf, 1'b0, '0, ST_DONE,  4'd0);
    add_row(CMD_POP_FRONT,  '0,            1'b0, '0, ST_DONE,  4'd0);

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (cmd_table[i]) begin
      send_cmd(cmd_table[i]);
    end

    // bias the push/pop mix per stretch so the queue swings between full and empty
    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 40 == 0) begin
        push_pct = $urandom_range(15, 85);
      end
      if ($urandom_range(0, 49) == 0) begin
        send_burst = ~send_burst;
      end
      row.typed   = 1'b0;
      row.outcome = '0;
      row.value   = pick_word();
      if ($urandom_range(0, 99) < push_pct) begin
        row.cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end else begin
        row.cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      send_cmd(row);
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    take_burst   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) begin
        take_burst = ~take_burst;
      end
      stall = draw_idle(take_burst);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    deq_result_t got;
    deq_result_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{value: out_if.out_value, status: out_if.status, fill: out_if.fill_count};
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result transfer: value %0d status %0d fill %0d",
                   got.value, got.status, got.fill);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.status !== want.status ||
            got.fill !== want.fill) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result mismatch: expected value %0d status %0d fill %0d, got value %0d status %0d fill %0d",
                     want.value, want.status, want.fill, got.value, got.status, got.fill);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
